@@ design/tpool_pkg.sv @@
// Shared types and constants of the token pool with reacquire holdoff.
package tpool_pkg;

   // Width of the configuration index and of its write data.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_ENABLED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TOKENS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_TICKS = 2'd2;

   // Fixed widths of the transaction fields.
   localparam int OP_W       = 3;
   localparam int CLIENT_W   = 4;
   localparam int ELAPSED_W  = 16;
   localparam int HOLDOFF_W  = 16;
   localparam int COUNT_W    = 5;

   // Operation codes carried by a request.
   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_ACQUIRE = 3'd1,
      OP_RELEASE = 3'd2,
      OP_FORGET  = 3'd3,
      OP_CLEAR   = 3'd4
   } tpool_op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_TICK,
      ST_MODIFY
   } tpool_state_type;

   // Configuration as seen by the pool logic.
   typedef struct packed {
      logic                 pool_enabled;
      logic [COUNT_W-1:0]   max_tokens;
      logic [HOLDOFF_W-1:0] holdoff_ticks;
   } tpool_cfg_type;

endpackage

@@ design/token_pool_with_reacquire_holdoff_top.sv @@
// Top level: client memory, sequencer and result register of the token pool.
// Acquire, release, forget and unused codes read their entry, pass through ST_MODIFY and
// register the result strobe. Tick and clear sweep the client memory, one entry a cycle.
// The read-modify-write goes through the memory's one read and one write port; start is
// taken again in the cycle that carries the result. The receiver cannot stall. After
// reset the memory is cleared by a sweep over all NUM_CLIENTS entries while busy is high.
module token_pool_with_reacquire_holdoff_top
   import tpool_pkg::*;
#(
   parameter int NUM_CLIENTS = 16,
   parameter int TIME_BITS   = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_W-1:0]        req_op,
   input  logic [CLIENT_W-1:0]    req_client_id,
   input  logic [ELAPSED_W-1:0]   req_elapsed,
   output logic                   rsp_valid,
   output logic                   rsp_granted,
   output logic                   rsp_holding,
   output logic [HOLDOFF_W-1:0]   rsp_holdoff_left,
   output logic [COUNT_W-1:0]     rsp_holder_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int HCW = $clog2(NUM_CLIENTS + 1);
   localparam int KW  = (HCW > COUNT_W) ? HCW : COUNT_W;
   localparam int EW  = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
   localparam int MW  = TIME_BITS + 1;
   localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CLIENTS - 1);

   tpool_cfg_type cfg;

   // Control state.
   tpool_state_type state_ff, state_in;
   logic            respond_ff, respond_in;
   logic [HCW-1:0]  count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Latched transaction and result payload.
   tpool_op_type          op_ff, op_in;
   logic [CLIENT_W-1:0]   cid_ff, cid_in;
   logic                  cid_ok_ff, cid_ok_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic                  rsp_granted_ff, rsp_granted_in;
   logic                  rsp_holding_ff, rsp_holding_in;
   logic [TIME_BITS-1:0]  rsp_timer_ff, rsp_timer_in;

   // Client memory: holder bit above the holdoff timer.
   logic [MW-1:0] client_mem [NUM_CLIENTS];
   logic [MW-1:0] mem_rdata_ff;
   logic          mem_re;
   logic [CW-1:0] mem_raddr;
   logic          mem_we;
   logic [CW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;

   // Helpers for the entry under modification.
   logic                 ent_hold;
   logic [TIME_BITS-1:0] ent_timer;
   logic [EW-1:0]        tick_timer;
   logic [EW-1:0]        tick_elapsed;
   logic [TIME_BITS-1:0] tick_next;
   logic                 load_wide;
   logic [TIME_BITS-1:0] load_value;
   logic                 below_max;
   logic                 accept;
   logic [CW-1:0]        cid_addr;

   tpool_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign accept           = start && !busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_holding      = rsp_holding_ff;
   assign rsp_holdoff_left = HOLDOFF_W'(rsp_timer_ff);
   assign rsp_holder_count = COUNT_W'(count_ff);

   // Fields of the entry read back from memory and derived values.
   assign ent_hold     = mem_rdata_ff[TIME_BITS];
   assign ent_timer    = mem_rdata_ff[TIME_BITS-1:0];
   assign tick_timer   = EW'(ent_timer);
   assign tick_elapsed = EW'(elapsed_ff);
   assign tick_next    = (tick_timer <= tick_elapsed) ? '0 :
                         TIME_BITS'(tick_timer - tick_elapsed);
   assign load_wide    = ((EW'(cfg.holdoff_ticks) >> TIME_BITS) != '0);
   assign load_value   = load_wide ? '1 : TIME_BITS'(cfg.holdoff_ticks);
   assign below_max    = (KW'(count_ff) < KW'(cfg.max_tokens));
   assign cid_addr     = CW'(cid_ff);

   // Sequencer: next state, memory accesses and result.
   always_comb begin
      logic                 new_hold;
      logic [TIME_BITS-1:0] new_timer;
      logic [HCW-1:0]       new_count;
      logic                 grant;

      new_hold  = ent_hold;
      new_timer = ent_timer;
      new_count = count_ff;
      grant     = 1'b0;

      state_in       = state_ff;
      respond_in     = respond_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = 1'b0;
      op_in          = op_ff;
      cid_in         = cid_ff;
      cid_ok_in      = cid_ok_ff;
      elapsed_in     = elapsed_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_holding_in = rsp_holding_ff;
      rsp_timer_in   = rsp_timer_ff;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in          = tpool_op_type'(req_op);
               cid_in         = req_client_id;
               cid_ok_in      = (int'(req_client_id) < NUM_CLIENTS);
               elapsed_in     = req_elapsed;
               rsp_granted_in = 1'b0;
               rsp_holding_in = 1'b0;
               rsp_timer_in   = '0;
               idx_in         = '0;
               mem_re         = 1'b1;
               case (tpool_op_type'(req_op))
                  OP_TICK: begin
                     mem_raddr = '0;
                     state_in  = ST_TICK;
                  end
                  OP_CLEAR: begin
                     respond_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     mem_raddr = CW'(req_client_id);
                     state_in  = ST_MODIFY;
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            idx_in    = CW'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               count_in     = '0;
               rsp_valid_in = respond_ff;
               respond_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_TICK: begin
            // Write back the entry that arrived and fetch the following one.
            mem_we    = 1'b1;
            mem_wdata = {ent_hold, tick_next};
            if (cid_ok_ff && (idx_ff == cid_addr)) begin
               rsp_holding_in = ent_hold;
               rsp_timer_in   = tick_next;
            end
            idx_in = CW'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = CW'(idx_ff + 1'b1);
            end
         end

         ST_MODIFY: begin
            case (op_ff)
               OP_ACQUIRE: begin
                  if (!cfg.pool_enabled || ent_hold) begin
                     grant = 1'b1;
                  end else if ((ent_timer == '0) && below_max) begin
                     new_hold  = 1'b1;
                     new_count = HCW'(count_ff + 1'b1);
                     grant     = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (ent_hold) begin
                     new_hold  = 1'b0;
                     new_count = HCW'(count_ff - 1'b1);
                     if (cfg.holdoff_ticks != '0) begin
                        new_timer = load_value;
                     end
                  end
               end
               OP_FORGET: begin
                  if (ent_hold) begin
                     new_hold  = 1'b0;
                     new_count = HCW'(count_ff - 1'b1);
                  end
                  new_timer = '0;
               end
               default: begin
                  new_hold = ent_hold;
               end
            endcase
            // An out-of-range client leaves every entry untouched.
            if (cid_ok_ff) begin
               mem_we         = 1'b1;
               mem_waddr      = cid_addr;
               mem_wdata      = {new_hold, new_timer};
               count_in       = new_count;
               rsp_granted_in = grant;
               rsp_holding_in = new_hold;
               rsp_timer_in   = new_timer;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         respond_ff   <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         respond_ff   <= respond_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction and result payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cid_ff         <= cid_in;
      cid_ok_ff      <= cid_ok_in;
      elapsed_ff     <= elapsed_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_holding_ff <= rsp_holding_in;
      rsp_timer_ff   <= rsp_timer_in;
   end

   // Client memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         client_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= client_mem[mem_raddr];
      end
   end

   // A result strobe only follows a busy cycle.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in progress");

   // An accepted transaction makes the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start work");

   // The holder count never exceeds the number of clients.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= NUM_CLIENTS)
      else $error("holder count above the number of clients");

   // A sweep never writes and reads the same entry in one cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("memory read and write collide on one entry");

endmodule

@@ design/tpool_csr.sv @@
// Configuration registers of the token pool.
module tpool_csr
   import tpool_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output tpool_cfg_type          cfg
);

   tpool_cfg_type cfg_ff;
   tpool_cfg_type cfg_in;

   // A write is always taken at once.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and update the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POOL_ENABLED:  cfg_in.pool_enabled  = csr_wdata[0];
            CSR_MAX_TOKENS:    cfg_in.max_tokens    = csr_wdata[COUNT_W-1:0];
            CSR_HOLDOFF_TICKS: cfg_in.holdoff_ticks = csr_wdata[HOLDOFF_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_enabled  <= 1'b1;
         cfg_ff.max_tokens    <= COUNT_W'(1);
         cfg_ff.holdoff_ticks <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sim/token_pool_with_reacquire_holdoff_top_tb.sv @@
// Self-checking testbench for the token pool with reacquire holdoff.
module token_pool_with_reacquire_holdoff_top_tb;
   import tpool_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CLIENTS = 16;
   localparam int TIME_BITS   = 16;
   localparam int CYCLE_LIMIT = 500000;
   // Longest sweep of the client memory plus a little margin.
   localparam int SETTLE_CYCLES = NUM_CLIENTS + 4;
   // Codes above the last named operation are unused.
   localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

   typedef struct {
      bit                 granted;
      bit                 holding;
      bit [HOLDOFF_W-1:0] holdoff_left;
      bit [COUNT_W-1:0]   holder_count;
   } pool_reply_type;

   // Mirror of the pool state; predicts one reply per accepted transaction.
   class token_pool_tracker;
      bit                 enabled;
      bit [COUNT_W-1:0]   max_holders;
      bit [HOLDOFF_W-1:0] holdoff_load;
      bit                 holder[NUM_CLIENTS];
      bit [TIME_BITS-1:0] timer[NUM_CLIENTS];
      bit [COUNT_W-1:0]   holder_total;
      pool_reply_type     awaited[$];
      int unsigned        mismatches;

      function new();
         enabled      = 1'b1;
         max_holders  = 1;
         holdoff_load = '0;
         mismatches   = 0;
         clear_clients();
      endfunction

      function void clear_clients();
         foreach (holder[i]) begin
            holder[i] = 1'b0;
            timer[i]  = '0;
         end
         holder_total = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_POOL_ENABLED:  enabled      = data[0];
            CSR_MAX_TOKENS:    max_holders  = data[COUNT_W-1:0];
            CSR_HOLDOFF_TICKS: holdoff_load = data[HOLDOFF_W-1:0];
            default: ;
         endcase
      endfunction

      function void apply_request(logic [OP_W-1:0] code, logic [CLIENT_W-1:0] client,
                                  logic [ELAPSED_W-1:0] ticks);
         pool_reply_type r;
         r.granted = 1'b0;
         case (code)
            OP_TICK: begin
               // Every running timer counts down and stops at zero.
               foreach (timer[i]) begin
                  if (timer[i] != 0)
                     timer[i] = (timer[i] <= ticks) ? '0 : timer[i] - ticks;
               end
            end
            OP_CLEAR: clear_clients();
            OP_ACQUIRE: begin
               if (!enabled || holder[client]) begin
                  r.granted = 1'b1;
               end else if (timer[client] == 0 && holder_total < max_holders) begin
                  holder[client] = 1'b1;
                  holder_total++;
                  r.granted = 1'b1;
               end
            end
            OP_RELEASE: begin
               // A release only matters for a holder; a zero holdoff leaves the timer alone.
               if (holder[client]) begin
                  holder[client] = 1'b0;
                  holder_total--;
                  if (holdoff_load != 0)
                     timer[client] = holdoff_load;
               end
            end
            OP_FORGET: begin
               if (holder[client]) begin
                  holder[client] = 1'b0;
                  holder_total--;
               end
               timer[client] = '0;
            end
            default: ;
         endcase
         r.holding      = holder[client];
         r.holdoff_left = timer[client];
         r.holder_count = holder_total;
         awaited.insert(awaited.size(), r);
      endfunction

      function void match_reply(logic granted, logic holding, logic [HOLDOFF_W-1:0] left,
                                logic [COUNT_W-1:0] count);
         pool_reply_type r;
         if (awaited.size() == 0) begin
            $error("reply with no transaction outstanding");
            mismatches++;
            return;
         end
         r = awaited.pop_front();
         if (granted !== r.granted) begin
            $error("granted: expected %0d, actual %0d", r.granted, granted);
            mismatches++;
         end
         if (holding !== r.holding) begin
            $error("holding: expected %0d, actual %0d", r.holding, holding);
            mismatches++;
         end
         if (left !== r.holdoff_left) begin
            $error("holdoff_left: expected %0d, actual %0d", r.holdoff_left, left);
            mismatches++;
         end
         if (count !== r.holder_count) begin
            $error("holder_count: expected %0d, actual %0d", r.holder_count, count);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OP_W-1:0]        req_op = '0;
   logic [CLIENT_W-1:0]    req_client_id = '0;
   logic [ELAPSED_W-1:0]   req_elapsed = '0;
   logic                   rsp_valid;
   logic                   rsp_granted;
   logic                   rsp_holding;
   logic [HOLDOFF_W-1:0]   rsp_holdoff_left;
   logic [COUNT_W-1:0]     rsp_holder_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   token_pool_tracker pool = new();
   int unsigned       cycle_count = 0;
   int unsigned       cur_holdoff = 0;

   token_pool_with_reacquire_holdoff_top #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .TIME_BITS   (TIME_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_client_id    (req_client_id),
      .req_elapsed      (req_elapsed),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_holding      (rsp_holding),
      .rsp_holdoff_left (rsp_holdoff_left),
      .rsp_holder_count (rsp_holder_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watch every handshake at the clock edge and keep the mirror in step.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            pool.match_reply(rsp_granted, rsp_holding, rsp_holdoff_left, rsp_holder_count);
         if (csr_valid && csr_ready)
            pool.write_register(csr_index, csr_wdata);
         if (start && !busy)
            pool.apply_request(req_op, req_client_id, req_elapsed);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("token_pool_with_reacquire_holdoff_top_tb failed");
         $finish;
      end
   end

   // Present one transaction and hold it until the block takes it.
   task automatic send_op(input logic [OP_W-1:0] code, input logic [CLIENT_W-1:0] client,
                          input logic [ELAPSED_W-1:0] ticks);
      start         <= 1'b1;
      req_op        <= code;
      req_client_id <= client;
      req_elapsed   <= ticks;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until every reply is in and the block is quiet.
   task automatic drain_pool();
      start <= 1'b0;
      @(posedge clock);
      while (pool.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic await_csr();
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write all three registers in one held-valid sequence.
   task automatic program_pool(input logic en, input int unsigned max_tok,
                               input int unsigned hold);
      csr_valid <= 1'b1;
      csr_index <= CSR_POOL_ENABLED;
      csr_wdata <= CSR_DATA_W'(en);
      await_csr();
      csr_index <= CSR_MAX_TOKENS;
      csr_wdata <= CSR_DATA_W'(max_tok);
      await_csr();
      csr_index <= CSR_HOLDOFF_TICKS;
      csr_wdata <= CSR_DATA_W'(hold);
      await_csr();
      csr_valid <= 1'b0;
      cur_holdoff = hold;
   endtask

   function automatic logic [OP_W-1:0] OP_OP_UNUSED_PICK();
      return OP_W'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE));
   endfunction

   // One random transaction, weighted towards contention on a few clients.
   task automatic send_random_op();
      logic [OP_W-1:0]      code;
      logic [CLIENT_W-1:0]  client;
      logic [ELAPSED_W-1:0] ticks;
      int unsigned          pick;
      int unsigned          span;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         code = OP_ACQUIRE;
      else if (pick < 65)
         code = OP_RELEASE;
      else if (pick < 85)
         code = OP_TICK;
      else if (pick < 92)
         code = OP_FORGET;
      else if (pick < 95)
         code = OP_CLEAR;
      else
         code = OP_OP_UNUSED_PICK();
      client = ($urandom_range(0, 9) < 6) ? CLIENT_W'($urandom_range(0, 5))
                                          : CLIENT_W'($urandom_range(0, NUM_CLIENTS - 1));
      // Scale elapsed time to the holdoff so that timers both run and expire.
      span = (cur_holdoff == 0) ? 64 : cur_holdoff / 3 + 1;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         ticks = '0;
      else if (pick < 25)
         ticks = ELAPSED_W'($urandom);
      else
         ticks = ELAPSED_W'($urandom_range(0, span));
      send_op(code, client, ticks);
   endtask

   // Random traffic in bursts, with a drain, a gap of random length or no gap between them.
   task automatic run_random_phase(input int unsigned items);
      int unsigned done;
      int unsigned burst;
      done = 0;
      while (done < items) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_random_op();
            done++;
         end
         if ($urandom_range(0, 39) == 0)
            drain_pool();
         else if ($urandom_range(0, 9) >= 3)
            pause_sender($urandom_range(1, 20));
      end
   endtask

   // Stimulus: directed corner cases, then random phases under several settings.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      // Reset settings: one token, no holdoff.
      send_op(OP_ACQUIRE, 0, 0);
      send_op(OP_ACQUIRE, 0, 0);
      send_op(OP_ACQUIRE, 15, 0);
      send_op(OP_RELEASE, 15, 0);
      send_op(OP_RELEASE, 0, 0);
      send_op(OP_W'(OP_CLEAR + 1), 3, 16'hFFFF);
      send_op(OP_LAST_CODE, 0, 0);
      drain_pool();

      // Full pool and the longest holdoff.
      program_pool(1'b1, NUM_CLIENTS, 16'hFFFF);
      send_op(OP_ACQUIRE, 15, 0);
      send_op(OP_ACQUIRE, 0, 0);
      send_op(OP_RELEASE, 15, 0);
      send_op(OP_ACQUIRE, 15, 0);
      send_op(OP_TICK, 15, 0);
      send_op(OP_TICK, 15, 1);
      send_op(OP_TICK, 15, 16'hFFFE);
      send_op(OP_ACQUIRE, 15, 0);
      send_op(OP_RELEASE, 15, 0);
      send_op(OP_TICK, 15, 16'hFFFF);
      send_op(OP_RELEASE, 0, 0);
      send_op(OP_FORGET, 0, 0);
      send_op(OP_ACQUIRE, 7, 0);
      send_op(OP_FORGET, 7, 0);
      send_op(OP_ACQUIRE, 9, 0);
      send_op(OP_CLEAR, 9, 0);
      drain_pool();

      // Pool disabled: grants are not recorded.
      program_pool(1'b0, 0, 0);
      send_op(OP_ACQUIRE, 9, 0);
      send_op(OP_RELEASE, 9, 0);
      drain_pool();

      // No tokens at all.
      program_pool(1'b1, 0, 0);
      send_op(OP_ACQUIRE, 2, 0);
      drain_pool();

      // Random phases under fixed and random settings.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_pool(1'b1, 2, 50);
            1: program_pool(1'b1, NUM_CLIENTS, 16'hFFFF);
            2: program_pool(1'b1, 0, 0);
            3: program_pool(1'b0, 3, 10);
            4: program_pool(1'b1, (1 << COUNT_W) - 1, 300);
            default: program_pool($urandom_range(0, 4) != 0, $urandom_range(0, 17),
                                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16'hFFFF)
                                                              : $urandom_range(0, 1000));
         endcase
         run_random_phase(180);
         drain_pool();
      end

      if (pool.mismatches == 0 && pool.outstanding() == 0) begin
         $display("token_pool_with_reacquire_holdoff_top_tb passed");
      end else begin
         $display("token_pool_with_reacquire_holdoff_top_tb failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/tpool_pkg.sv
design/tpool_csr.sv
design/token_pool_with_reacquire_holdoff_top.sv
sim/token_pool_with_reacquire_holdoff_top_tb.sv
